// File: hw/rtl/esu_pkg.sv
// Shared types and constants for the executable header screen.
`timescale 1ns / 1ps

package esu_pkg;

  // File geometry.
  localparam int HEADER_BYTES  = 64;
  localparam int HDR_AW        = $clog2(HEADER_BYTES);
  localparam int ALPHABET_SIZE = 256;
  localparam int POS_W         = 25;
  localparam int OFFSET_W      = 32;
  localparam int DIST_W        = 9;
  localparam int SCORE_W       = 17;

  localparam logic [POS_W-1:0] POS_MAX = {POS_W{1'b1}};

  // Header byte positions of the little-endian PE offset field.
  localparam logic [HDR_AW-1:0] OFF_B0 = 6'h3C;
  localparam logic [HDR_AW-1:0] OFF_B1 = 6'h3D;
  localparam logic [HDR_AW-1:0] OFF_B2 = 6'h3E;

  // Signature characters.
  localparam logic [7:0] CHAR_M  = 8'h4D;
  localparam logic [7:0] CHAR_Z  = 8'h5A;
  localparam logic [7:0] CHAR_LT = 8'h3C;
  localparam logic [7:0] CHAR_QM = 8'h3F;
  localparam logic [7:0] CHAR_P  = 8'h50;
  localparam logic [7:0] CHAR_E  = 8'h45;

  // Score awards.
  localparam logic [SCORE_W-1:0] MZ_POINTS = 17'd10;
  localparam logic [SCORE_W-1:0] PE_POINTS = 17'd15;

  // Configuration register indexes and reset values.
  localparam logic [1:0] REG_BASE_SCORE = 2'd0;
  localparam logic [1:0] REG_THRESHOLD  = 2'd1;
  localparam logic [1:0] REG_MAX_FILE   = 2'd2;
  localparam logic [1:0] REG_MAX_LOOP   = 2'd3;

  localparam logic [15:0] RST_BASE_SCORE = 16'd0;
  localparam logic [15:0] RST_THRESHOLD  = 16'd50;
  localparam logic [23:0] RST_MAX_FILE   = 24'd10485760;
  localparam logic [23:0] RST_MAX_LOOP   = 24'd5000000;

  // Summary queue depth.
  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);

  typedef enum logic [1:0] {
    ST_SUCCESS    = 2'd0,
    ST_SUSPICIOUS = 2'd1,
    ST_CRITICAL   = 2'd2,
    ST_ERROR      = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    HDR_PLAIN = 2'd0,
    HDR_MZ    = 2'd1,
    HDR_CRIT  = 2'd2
  } hdr_class_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    status_t              status;
    logic [SCORE_W-1:0]   final_score;
    logic [DIST_W-1:0]    distinct_values;
  } out_item_t;

  typedef struct packed {
    logic [15:0] base_score;
    logic [15:0] suspicious_threshold;
    logic [23:0] max_file_bytes;
    logic [23:0] max_loop_bytes;
  } cfg_t;

  // One finished file as classified by the front end.
  typedef struct packed {
    logic [POS_W-1:0]    len;
    hdr_class_t          hdr_class;
    logic                pe_cand;
    logic [OFFSET_W-1:0] offset;
    logic [DIST_W-1:0]   distinct;
  } summary_t;

endpackage

// File: hw/rtl/esu_front.sv
// Byte front end: tracks header, signature and distinct values per file.
`timescale 1ns / 1ps

module esu_front import esu_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     item_acc,
  input  in_item_t in_item,
  output logic     sum_push,
  output summary_t sum_item
);

  logic [POS_W-1:0]         pos_r, pos_nxt;
  logic [7:0]               byte0_r, byte0_nxt;
  logic [7:0]               byte1_r, byte1_nxt;
  logic [23:0]              off_lo_r, off_lo_nxt;
  logic [HEADER_BYTES-1:0]  p_flag_r, p_flag_nxt;
  logic [HEADER_BYTES-1:0]  e_flag_r, e_flag_nxt;
  logic [OFFSET_W-1:0]      offset_r, offset_nxt;
  logic                     sig_r, sig_nxt;
  logic                     half_r, half_nxt;
  logic [ALPHABET_SIZE-1:0] seen_r, seen_nxt;
  logic [DIST_W-1:0]        dcount_r, dcount_nxt;

  logic [7:0]               b;
  logic                     in_hdr;
  logic [HDR_AW-1:0]        pidx;
  logic [OFFSET_W-1:0]      o;
  logic [HDR_AW-1:0]        o_next;
  logic                     e_at_next;
  logic [POS_W-1:0]         len;
  logic [7:0]               b0_eff, b1_eff;
  logic                     two_bytes, is_mz, is_crit;

  assign b      = in_item.data_byte;
  assign in_hdr = (pos_r[POS_W-1:HDR_AW] == '0);
  assign pidx   = pos_r[HDR_AW-1:0];
  assign o      = {b, off_lo_r};
  assign o_next = o[HDR_AW-1:0] + 6'd1;
  assign len    = (pos_r == POS_MAX) ? pos_r : pos_r + 25'd1;

  // The byte after the offset may be the one arriving now.
  assign e_at_next = (o_next == pidx) ? (b == CHAR_E) : e_flag_r[o_next];

  // Per-byte state update.
  always_comb begin
    byte0_nxt  = byte0_r;
    byte1_nxt  = byte1_r;
    off_lo_nxt = off_lo_r;
    p_flag_nxt = p_flag_r;
    e_flag_nxt = e_flag_r;
    offset_nxt = offset_r;
    sig_nxt    = sig_r;
    half_nxt   = half_r;
    seen_nxt   = seen_r;
    dcount_nxt = dcount_r;
    if (in_hdr) begin
      p_flag_nxt[pidx] = (b == CHAR_P);
      e_flag_nxt[pidx] = (b == CHAR_E);
      if (pidx == 6'd0) byte0_nxt = b;
      if (pidx == 6'd1) byte1_nxt = b;
      if (pidx == OFF_B0) off_lo_nxt[7:0]   = b;
      if (pidx == OFF_B1) off_lo_nxt[15:8]  = b;
      if (pidx == OFF_B2) off_lo_nxt[23:16] = b;
    end
    if (!seen_r[b]) begin
      seen_nxt[b] = 1'b1;
      dcount_nxt  = dcount_r + 9'd1;
    end
    if (pos_r == POS_W'(HEADER_BYTES - 1)) begin
      offset_nxt = o;
      if (o < OFFSET_W'(HEADER_BYTES - 1)) begin
        sig_nxt = p_flag_r[o[HDR_AW-1:0]] && e_at_next;
      end else if (o == OFFSET_W'(HEADER_BYTES - 1)) begin
        half_nxt = (b == CHAR_P);
      end
    end else if (!in_hdr) begin
      if (half_r && (b == CHAR_E)) sig_nxt = 1'b1;
      half_nxt = (offset_r == {{(OFFSET_W-POS_W){1'b0}}, pos_r}) && (b == CHAR_P);
    end
  end

  // Header classification of a file ending with this byte.
  assign b0_eff    = (pos_r == '0) ? b : byte0_r;
  assign b1_eff    = (pos_r == POS_W'(1)) ? b : byte1_r;
  assign two_bytes = (pos_r != '0);
  assign is_mz     = two_bytes && (b0_eff == CHAR_M) && (b1_eff == CHAR_Z);
  assign is_crit   = two_bytes && !is_mz && (b0_eff == CHAR_LT) && (b1_eff == CHAR_QM);

  // A PE award needs a complete header, which includes a file of exactly that size.
  always_comb begin
    sum_item.len       = len;
    sum_item.hdr_class = is_mz ? HDR_MZ : (is_crit ? HDR_CRIT : HDR_PLAIN);
    sum_item.pe_cand   = is_mz && (len >= POS_W'(HEADER_BYTES)) && sig_nxt;
    sum_item.offset    = offset_nxt;
    sum_item.distinct  = dcount_nxt;
  end

  assign sum_push = item_acc && in_item.last_byte;

  // Per-file control state, cleared after the final byte.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r    <= '0;
      offset_r <= '0;
      sig_r    <= 1'b0;
      half_r   <= 1'b0;
      seen_r   <= '0;
      dcount_r <= '0;
    end else if (item_acc) begin
      if (in_item.last_byte) begin
        pos_r    <= '0;
        offset_r <= '0;
        sig_r    <= 1'b0;
        half_r   <= 1'b0;
        seen_r   <= '0;
        dcount_r <= '0;
      end else begin
        pos_r    <= len;
        offset_r <= offset_nxt;
        sig_r    <= sig_nxt;
        half_r   <= half_nxt;
        seen_r   <= seen_nxt;
        dcount_r <= dcount_nxt;
      end
    end
  end

  // Header bytes and flags are always written before they are read.
  always_ff @(posedge clk) begin
    if (item_acc) begin
      byte0_r  <= byte0_nxt;
      byte1_r  <= byte1_nxt;
      off_lo_r <= off_lo_nxt;
      p_flag_r <= p_flag_nxt;
      e_flag_r <= e_flag_nxt;
    end
  end

endmodule

// File: hw/rtl/esu_queue.sv
// Short first-in first-out queue of file summaries between front and back.
`timescale 1ns / 1ps

module esu_queue import esu_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  input  summary_t wr_item,
  output logic     full,
  input  logic     pop,
  output summary_t rd_item,
  output logic     empty
);

  summary_t         mem_r [QDEPTH];
  logic [QAW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [QAW:0]     count_r;
  logic             do_push, do_pop;

  assign full    = (count_r == (QAW+1)'(QDEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_item = mem_r[rd_ptr_r];

  // Pointer and fill bookkeeping.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (do_pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      if (do_push && !do_pop) count_r <= count_r + 1'b1;
      else if (do_pop && !do_push) count_r <= count_r - 1'b1;
    end
  end

  // Storage.
  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= wr_item;
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= (QAW+1)'(QDEPTH))
    else $error("summary queue overfilled");

  a_push_full_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (full && !pop) |=> full)
    else $error("summary queue lost an entry while full");

endmodule

// File: hw/rtl/esu_back.sv
// Result back end: length checks, scoring and the output register.
`timescale 1ns / 1ps

module esu_back import esu_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  cfg_t      cfg,
  input  logic      q_empty,
  input  summary_t  q_item,
  output logic      q_pop,
  output logic      out_empty,
  input  logic      out_pop,
  output out_item_t out_item
);

  typedef struct packed {
    hdr_class_t        hdr_class;
    logic              hard_err;
    logic              loop_err;
    logic              pe_ok;
    logic [DIST_W-1:0] distinct;
  } stage_a_t;

  stage_a_t          a_r, a_nxt;
  logic              a_v_r;
  out_item_t         out_r, out_nxt;
  logic              out_v_r;
  logic              a_ready, b_ready;
  logic [OFFSET_W:0] off_end;
  logic [SCORE_W-1:0] base_ext, score;

  assign b_ready = !out_v_r || out_pop;
  assign a_ready = !a_v_r || b_ready;
  assign q_pop   = !q_empty && a_ready;

  // Stage A: length limits and PE offset range.
  assign off_end = {1'b0, q_item.offset} + 33'd4;
  always_comb begin
    a_nxt.hdr_class = q_item.hdr_class;
    a_nxt.hard_err  = q_item.len > {1'b0, cfg.max_file_bytes};
    a_nxt.loop_err  = q_item.len > {1'b0, cfg.max_loop_bytes};
    a_nxt.pe_ok     = q_item.pe_cand &&
                      (off_end <= {{(OFFSET_W+1-POS_W){1'b0}}, q_item.len});
    a_nxt.distinct  = q_item.distinct;
  end

  // Stage B: score and status in check order.
  assign base_ext = {1'b0, cfg.base_score};
  always_comb begin
    score = base_ext;
    if (!a_r.hard_err && (a_r.hdr_class == HDR_MZ)) begin
      score = base_ext + (a_r.pe_ok ? (MZ_POINTS + PE_POINTS) : MZ_POINTS);
    end
    out_nxt.final_score     = score;
    out_nxt.distinct_values = a_r.distinct;
    priority if (a_r.hard_err) out_nxt.status = ST_ERROR;
    else if (a_r.hdr_class == HDR_CRIT) out_nxt.status = ST_CRITICAL;
    else if (a_r.loop_err) out_nxt.status = ST_ERROR;
    else if (score >= base_ext - base_ext + {1'b0, cfg.suspicious_threshold})
      out_nxt.status = ST_SUSPICIOUS;
    else out_nxt.status = ST_SUCCESS;
  end

  // Valid flags of both stages.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r   <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (a_ready) a_v_r <= q_pop;
      if (b_ready) out_v_r <= a_v_r;
    end
  end

  // Stage payloads.
  always_ff @(posedge clk) begin
    if (q_pop) a_r <= a_nxt;
    if (b_ready && a_v_r) out_r <= out_nxt;
  end

  assign out_empty = !out_v_r;
  assign out_item  = out_r;

  a_crit_base: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && (out_r.status == ST_CRITICAL)) |-> (out_r.final_score == base_ext))
    else $error("critical result carries header points");

  a_score_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r |-> (out_r.final_score <= base_ext + MZ_POINTS + PE_POINTS))
    else $error("result score above the largest award");

  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    (!a_v_r && (!out_v_r || out_pop)) |=> !out_v_r)
    else $error("result appeared without a stage A item");

endmodule

// File: hw/rtl/executable_header_screen_unit.sv
// Top level of the executable header screen: registers and channel wiring.
`timescale 1ns / 1ps

// Screens files streamed one byte per item. Push bytes on in_item while
// in_full is low; last_byte marks the final byte of a file. For every file
// one result item appears on out_item (status, final_score, distinct_values)
// while out_empty is low; pop takes it.
// Throughput: one byte per cycle while in_full is low; the front end updates
// position, seen map and signature tracking per byte. Files of one byte
// each give one result per cycle through the back end while out_pop is high.
// A file's summary is queued when its final byte is accepted, then passes
// the range-check stage and the output register before out_empty falls.
// A four-entry summary queue separates the front end from the back end, so
// bytes keep flowing while results wait; in_full rises only once the queue
// fills behind a stalled receiver. Configuration must be written through
// cfg_we/cfg_index/cfg_data only while idle; the block itself does not enforce this.
// Synchronous reset clears all queues and per-file state and loads the
// register defaults; no clearing pass is needed after reset.
module executable_header_screen_unit import esu_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_push,
  input  in_item_t  in_item,
  output logic      in_full,
  output logic      out_empty,
  input  logic      out_pop,
  output out_item_t out_item,
  input  logic      cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [23:0] cfg_data
);

  cfg_t     cfg_r;
  logic     item_acc;
  logic     sum_push, q_full, q_empty, q_pop;
  summary_t sum_item, q_item;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.base_score           <= RST_BASE_SCORE;
      cfg_r.suspicious_threshold <= RST_THRESHOLD;
      cfg_r.max_file_bytes       <= RST_MAX_FILE;
      cfg_r.max_loop_bytes       <= RST_MAX_LOOP;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_BASE_SCORE: cfg_r.base_score           <= cfg_data[15:0];
        REG_THRESHOLD:  cfg_r.suspicious_threshold <= cfg_data[15:0];
        REG_MAX_FILE:   cfg_r.max_file_bytes       <= cfg_data;
        REG_MAX_LOOP:   cfg_r.max_loop_bytes       <= cfg_data;
        default: ;
      endcase
    end
  end

  assign in_full  = q_full;
  assign item_acc = in_push && !q_full;

  esu_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .item_acc (item_acc),
    .in_item  (in_item),
    .sum_push (sum_push),
    .sum_item (sum_item)
  );

  esu_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (sum_push),
    .wr_item (sum_item),
    .full    (q_full),
    .pop     (q_pop),
    .rd_item (q_item),
    .empty   (q_empty)
  );

  esu_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .q_empty   (q_empty),
    .q_item    (q_item),
    .q_pop     (q_pop),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_item  (out_item)
  );

endmodule

// File: test/executable_header_screen_unit_tb.sv
// Self-checking testbench for the executable header screen top level.
`timescale 1ns / 1ps

module executable_header_screen_unit_tb import esu_pkg::*; ;

  localparam int CYCLE_LIMIT     = 200000;
  localparam int NUM_PHASES      = 8;
  localparam int FILES_PER_PHASE = 2;
  localparam int HOLD_CYCLES     = 300;
  localparam int SETTLE_CYCLES   = 8;
  localparam logic [23:0] MAX24  = 24'hFF_FFFF;

  // Predicts the summary of each screened file and checks the results against it.
  class screen_scoreboard;
    logic [15:0]         base_pts;
    logic [15:0]         alarm_at;
    logic [23:0]         hard_limit;
    logic [23:0]         scan_limit;
    logic [POS_W-1:0]    seen_bytes;
    logic [7:0]          head [HEADER_BYTES];
    logic [OFFSET_W-1:0] jump_offset;
    bit                  pe_found;
    bit                  p_at_offset;
    bit [ALPHABET_SIZE-1:0] value_seen;
    logic [DIST_W-1:0]   value_count;
    out_item_t           due [$];
    int                  errors;

    function new();
      base_pts   = RST_BASE_SCORE;
      alarm_at   = RST_THRESHOLD;
      hard_limit = RST_MAX_FILE;
      scan_limit = RST_MAX_LOOP;
      foreach (head[i]) head[i] = 8'h00;
      errors = 0;
      restart_file();
    endfunction

    // Per-file state goes back to zero after every summary.
    function void restart_file();
      seen_bytes  = '0;
      jump_offset = '0;
      pe_found    = 1'b0;
      p_at_offset = 1'b0;
      value_seen  = '0;
      value_count = '0;
    endfunction

    function void set_config(logic [15:0] base, logic [15:0] thr,
                             logic [23:0] flim, logic [23:0] llim);
      base_pts   = base;
      alarm_at   = thr;
      hard_limit = flim;
      scan_limit = llim;
    endfunction

    function int pending();
      return due.size();
    endfunction

    // Advances the predicted state by one accepted byte.
    function void note_byte(in_item_t it);
      logic [7:0]          b;
      logic [POS_W-1:0]    pos;
      logic [POS_W-1:0]    len;
      logic [OFFSET_W-1:0] o;
      logic [SCORE_W-1:0]  score;
      logic                is_mz;
      out_item_t           r;
      b   = it.data_byte;
      pos = seen_bytes;
      if (pos < HEADER_BYTES) head[pos[HDR_AW-1:0]] = b;
      if (!value_seen[b]) begin
        value_seen[b] = 1'b1;
        value_count++;
      end

      // The offset field is complete with the last header byte.
      if (pos == HEADER_BYTES - 1) begin
        o = {head[63], head[62], head[61], head[60]};
        jump_offset = o;
        if (o < HEADER_BYTES - 1) begin
          pe_found = (head[o[HDR_AW-1:0]] == CHAR_P) &&
                     (head[o[HDR_AW-1:0] + 1'b1] == CHAR_E);
        end else if (o == HEADER_BYTES - 1) begin
          p_at_offset = (head[HEADER_BYTES-1] == CHAR_P);
        end
      end else if (pos >= HEADER_BYTES) begin
        if (p_at_offset && b == CHAR_E) pe_found = 1'b1;
        p_at_offset = (jump_offset == {{(OFFSET_W-POS_W){1'b0}}, pos}) && (b == CHAR_P);
      end
      if (seen_bytes != POS_MAX) seen_bytes++;
      if (!it.last_byte) return;

      // The final byte closes the file and the checks run in order.
      len   = seen_bytes;
      score = {1'b0, base_pts};
      if (len > hard_limit) begin
        r.status = ST_ERROR;
      end else begin
        is_mz = (len >= 2) && (head[0] == CHAR_M) && (head[1] == CHAR_Z);
        if (!is_mz && len >= 2 && head[0] == CHAR_LT && head[1] == CHAR_QM) begin
          r.status = ST_CRITICAL;
        end else begin
          if (is_mz) begin
            score += MZ_POINTS;
            if (len >= HEADER_BYTES && pe_found &&
                ({1'b0, jump_offset} + 33'd4 <= {8'd0, len}))
              score += PE_POINTS;
          end
          if (len > scan_limit) r.status = ST_ERROR;
          else if (score >= {1'b0, alarm_at}) r.status = ST_SUSPICIOUS;
          else r.status = ST_SUCCESS;
        end
      end
      r.final_score     = score;
      r.distinct_values = value_count;
      due.push_back(r);
      restart_file();
    endfunction

    task report(string msg);
      if (errors < 40) $display("MISMATCH: %s", msg);
      errors++;
    endtask

    // Compares one popped summary with the oldest prediction.
    task check_result(out_item_t got);
      out_item_t exp;
      if (due.size() == 0) begin
        report($sformatf("unexpected result status %0d score %0d distinct %0d",
                         got.status, got.final_score, got.distinct_values));
        return;
      end
      exp = due.pop_front();
      if (got.status != exp.status)
        report($sformatf("status got %0d want %0d", got.status, exp.status));
      if (got.final_score != exp.final_score)
        report($sformatf("final_score got %0d want %0d", got.final_score,
                         exp.final_score));
      if (got.distinct_values != exp.distinct_values)
        report($sformatf("distinct_values got %0d want %0d", got.distinct_values,
                         exp.distinct_values));
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_push;
  in_item_t    in_item;
  logic        in_full;
  logic        out_empty;
  logic        out_pop;
  out_item_t   out_item;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [23:0] cfg_data;

  screen_scoreboard sb;
  logic [7:0] fbuf [$];
  bit         tx_idle_on;
  bit         rx_idle_on;
  bit         hold_ask;
  int         cycles;

  executable_header_screen_unit i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_item   (in_item),
    .in_full   (in_full),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_item  (out_item),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Free-running 10 ns clock.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Fills the file buffer with random bytes.
  task build_random(input int unsigned len);
    fbuf.delete();
    repeat (len) fbuf.push_back(8'($urandom_range(0, 255)));
  endtask

  // Builds an MZ file with the given PE offset, optionally placing "PE" there.
  task build_mz(input int unsigned len, input logic [31:0] off, input bit put_pe);
    build_random(len);
    fbuf[0] = CHAR_M;
    if (len > 1) fbuf[1] = CHAR_Z;
    if (len >= HEADER_BYTES) begin
      fbuf[60] = off[7:0];
      fbuf[61] = off[15:8];
      fbuf[62] = off[23:16];
      fbuf[63] = off[31:24];
    end
    // Only offsets clear of the magic and the offset field are stamped.
    if (put_pe && ((off >= 2 && off <= 58) || (off >= HEADER_BYTES && off < len))) begin
      fbuf[off] = CHAR_P;
      if (off + 1 < len) fbuf[off + 1] = CHAR_E;
    end
  endtask

  // A shuffled file holding every byte value once.
  task build_all_values();
    int j;
    logic [7:0] t;
    fbuf.delete();
    for (int i = 0; i < ALPHABET_SIZE; i++) fbuf.push_back(8'(i));
    for (int i = ALPHABET_SIZE - 1; i > 0; i--) begin
      j = $urandom_range(0, i);
      t = fbuf[i];
      fbuf[i] = fbuf[j];
      fbuf[j] = t;
    end
  endtask

  // Mostly MZ files with random content, some "<?" files, the rest noise.
  task random_file();
    int unsigned pick;
    int unsigned len;
    logic [31:0] off;
    pick = $urandom_range(0, 9);
    if (pick <= 5) begin
      len = ($urandom_range(0, 3) == 0) ? $urandom_range(2, 40) : $urandom_range(64, 72);
      case ($urandom_range(0, 4))
        0:       off = $urandom_range(2, 58);
        1, 2:    off = (len >= HEADER_BYTES) ? $urandom_range(64, len + 2)
                                             : $urandom_range(2, 58);
        3:       off = $urandom;
        default: off = 32'hFFFF_FFFF - $urandom_range(0, 3);
      endcase
      build_mz(len, off, $urandom_range(0, 4) != 0);
      if ($urandom_range(0, 7) == 0) fbuf[1] = 8'($urandom_range(0, 255));
    end else if (pick == 6) begin
      build_random($urandom_range(2, 30));
      fbuf[0] = CHAR_LT;
      fbuf[1] = ($urandom_range(0, 5) == 0) ? 8'($urandom_range(0, 255)) : CHAR_QM;
    end else if (pick <= 8) begin
      if ($urandom_range(0, 40) == 0) build_all_values();
      else build_random($urandom_range(1, 40));
    end else begin
      build_random(1);
    end
  endtask

  // Offers one item and returns at the edge where it is taken.
  task push_byte(input in_item_t it);
    if (tx_idle_on && $urandom_range(0, 99) < 26) begin
      in_push <= 1'b0;
      @(posedge clk);
      while ($urandom_range(0, 99) < 26) @(posedge clk);
    end
    in_push <= 1'b1;
    in_item <= it;
    @(posedge clk);
    while (in_full) @(posedge clk);
    sb.note_byte(it);
  endtask

  task send_file();
    in_item_t it;
    for (int i = 0; i < fbuf.size(); i++) begin
      it.data_byte = fbuf[i];
      it.last_byte = (i == fbuf.size() - 1);
      push_byte(it);
    end
  endtask

  // Stops sending and waits until every predicted summary has been popped.
  task wait_drained();
    in_push <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Writes all four registers, one per cycle, with junk above the 16-bit fields.
  task load_cfg(input logic [15:0] base, input logic [15:0] thr,
                input logic [23:0] flim, input logic [23:0] llim);
    logic [23:0] vals [4];
    logic [1:0]  idx [4];
    idx[0]  = REG_BASE_SCORE;
    idx[1]  = REG_THRESHOLD;
    idx[2]  = REG_MAX_FILE;
    idx[3]  = REG_MAX_LOOP;
    vals[0] = {8'($urandom_range(0, 255)), base};
    vals[1] = {8'($urandom_range(0, 255)), thr};
    vals[2] = flim;
    vals[3] = llim;
    for (int i = 0; i < 4; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= idx[i];
      cfg_data  <= vals[i];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    sb.set_config(base, thr, flim, llim);
  endtask

  // Result side: pops at random, and holds off for a long stretch on request.
  initial begin : receiver
    int hold_left;
    hold_left = 0;
    out_pop   = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_pop && !out_empty) sb.check_result(out_item);
      if (hold_ask) begin
        hold_left = HOLD_CYCLES;
        hold_ask  = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_pop <= 1'b0;
      end else if (!rst_n) begin
        out_pop <= 1'b0;
      end else begin
        out_pop <= !rx_idle_on || ($urandom_range(0, 99) >= 26);
      end
    end
  end

  // Ends a hung run.
  initial begin : watchdog
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("** executable_header_screen_unit: FAILED **");
    $finish;
  end

  // Main sequence: reset, directed files at reset settings, then random phases.
  initial begin : stimulus
    sb         = new();
    rst_n      = 1'b0;
    in_push    = 1'b0;
    in_item    = '0;
    cfg_we     = 1'b0;
    cfg_index  = REG_BASE_SCORE;
    cfg_data   = '0;
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
    hold_ask   = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed files: one-byte extremes, bare magics, and the PE offset corners.
    build_random(1); fbuf[0] = 8'h00; send_file();
    build_random(1); fbuf[0] = 8'hFF; send_file();
    build_random(1); fbuf[0] = CHAR_M; send_file();
    build_mz(2, 0, 1'b0); send_file();
    build_random(2); fbuf[0] = CHAR_LT; fbuf[1] = CHAR_QM; send_file();
    build_mz(64, 16, 1'b1); send_file();
    build_mz(68, 64, 1'b1); send_file();

    // Random phases, each under its own register setting.
    for (int ph = 1; ph <= NUM_PHASES; ph++) begin
      wait_drained();
      case (ph)
        1: load_cfg(16'd40, 16'd50, MAX24, MAX24);
        2: load_cfg(16'hFFFF, 16'hFFFF, 24'd1, 24'd1);
        3: load_cfg(16'hFFFF, 16'd0, MAX24, MAX24);
        4: load_cfg(16'd0, 16'd0, 24'd80, 24'd60);
        5: load_cfg(16'd0, 16'd25, MAX24, 24'd70);
        NUM_PHASES: load_cfg(RST_BASE_SCORE, RST_THRESHOLD, RST_MAX_FILE, RST_MAX_LOOP);
        default: load_cfg(16'($urandom_range(0, 60)),
                          ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 65535))
                                                      : 16'($urandom_range(0, 80)),
                          24'($urandom_range(30, 150)), 24'($urandom_range(20, 150)));
      endcase
      tx_idle_on = (ph != 5);
      rx_idle_on = (ph != 5);

      // Stall the receiver while one-byte files pile up behind it.
      if (ph == 3) begin
        hold_ask = 1'b1;
        repeat (20) begin
          build_random(1);
          send_file();
        end
      end
      repeat (FILES_PER_PHASE) begin
        random_file();
        send_file();
      end
    end

    wait_drained();
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("** executable_header_screen_unit: PASSED **");
    end else begin
      $display("** executable_header_screen_unit: FAILED **");
    end
    $finish;
  end

endmodule
